@@ design/ssl_pkg.sv @@
// ----------------------------------------------------------------------------
// ssl_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int DATA_W     = 32;
  localparam int TOTAL_W    = 7;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic rd_en;
    logic rd_down;
    logic scan_step;
    logic emit_start;
    logic emit_step;
    logic out_load;
    logic out_none;
    logic clear;
  } ssl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic emit_last;
    logic mark_set;
    logic kept_zero;
    logic out_free;
  } ssl_status_t;

endpackage

@@ design/suffix_sum_leader_filter.sv @@
// ----------------------------------------------------------------------------
// suffix_sum_leader_filter
// keeps list elements greater than the exact sum of all elements to their right
// ----------------------------------------------------------------------------
// channel  dir  tdata                           tlast       tuser
// s_*      in   [31:0] value                    is_final    -
// m_*      out  [31:0] kept_value, [38:32]      end_of_run  [0] none_found,
//               kept_total, [39] zero                       [1] dropped
//
// load accepts one transfer per cycle; input is held off from the final
// transfer until the last result of that list is in the output register.
// after the final transfer: a setup state, then a read and a compare state per
// element for the reverse scan, a state to start emission, then a read and a
// check state per element, as the element memory read is registered.
// output stalls hold the emission pass; rst is synchronous and empties the list.
// ----------------------------------------------------------------------------
module suffix_sum_leader_filter #(
  parameter int MAX_ITEMS  = ssl_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = ssl_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ssl_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ssl_pkg::OUT_DATA_W-1:0] m_tdata,   // kept_value, kept_total
  output logic                           m_tlast,
  output logic [ssl_pkg::OUT_USER_W-1:0] m_tuser    // none_found, dropped
);
  import ssl_pkg::*;

  ssl_cmd_t    cmd;
  ssl_status_t status;

  ssl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ssl_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_value (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ design/ssl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssl_ctrl
// sequencer for load, reverse scan and in-order emission passes
// ----------------------------------------------------------------------------
module ssl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tlast,
  output logic                s_tready,
  input  ssl_pkg::ssl_status_t status,
  output ssl_pkg::ssl_cmd_t    cmd
);
  import ssl_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_INIT,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_NONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_LOAD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            state_next = ST_SCAN_INIT;
          end
        end
      end
      ST_SCAN_INIT: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_down = 1'b1;
        state_next  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        state_next    = status.scan_last ? ST_EMIT_INIT : ST_SCAN_RD;
      end
      ST_EMIT_INIT: begin
        cmd.emit_start = 1'b1;
        state_next     = status.kept_zero ? ST_NONE : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EMIT_CHK;
      end
      ST_EMIT_CHK: begin
        if (!status.mark_set || status.out_free) begin
          cmd.out_load = status.mark_set;
          if (status.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.emit_step = 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      ST_NONE: begin
        if (status.out_free) begin
          cmd.out_none = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ design/ssl_dp.sv @@
// ----------------------------------------------------------------------------
// ssl_dp
// element memory, suffix accumulator, keep marks and output register
// ----------------------------------------------------------------------------
module ssl_dp #(
  parameter int MAX_ITEMS  = ssl_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = ssl_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ssl_pkg::DATA_W-1:0]         in_value,
  input  ssl_pkg::ssl_cmd_t                  cmd,
  output ssl_pkg::ssl_status_t               status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ssl_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast,
  output logic [ssl_pkg::OUT_USER_W-1:0]     m_tuser
);
  import ssl_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
  localparam int IDX_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_BITS = VALUE_BITS + CNT_BITS + 1;

  logic signed [VALUE_BITS-1:0] mem [MAX_ITEMS];
  logic signed [VALUE_BITS-1:0] rd_data;

  logic [CNT_BITS-1:0]        fill;
  logic [CNT_BITS-1:0]        ptr;
  logic [CNT_BITS-1:0]        kept;
  logic [CNT_BITS-1:0]        emitted;
  logic signed [SUM_BITS-1:0] right_sum;
  logic [MAX_ITEMS-1:0]       marks;
  logic                       ovf;

  logic [CNT_BITS-1:0]        ptr_dec;
  logic [IDX_BITS-1:0]        rd_addr;
  logic [IDX_BITS-1:0]        scan_idx;
  logic [IDX_BITS-1:0]        emit_idx;
  logic signed [SUM_BITS-1:0] elem_ext;
  logic                       full;
  logic                       keep;

  logic [DATA_W-1:0]  out_value;
  logic [TOTAL_W-1:0] out_total;
  logic               out_last;
  logic               out_none_flag;
  logic               out_drop;

  assign ptr_dec  = ptr - CNT_BITS'(1);
  assign scan_idx = ptr_dec[IDX_BITS-1:0];
  assign emit_idx = ptr[IDX_BITS-1:0];
  assign rd_addr  = cmd.rd_down ? scan_idx : emit_idx;
  assign full     = (fill == CNT_BITS'(MAX_ITEMS));
  assign elem_ext = SUM_BITS'(rd_data);
  assign keep     = (elem_ext > right_sum);

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[fill[IDX_BITS-1:0]] <= in_value[VALUE_BITS-1:0];
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      ovf       <= 1'b0;
      ptr       <= '0;
      kept      <= '0;
      emitted   <= '0;
      right_sum <= '0;
      marks     <= '0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          fill <= fill + CNT_BITS'(1);
        end
      end
      if (cmd.scan_start) begin
        ptr       <= fill;
        kept      <= '0;
        right_sum <= '0;
        marks     <= '0;
      end
      if (cmd.scan_step) begin
        ptr       <= ptr_dec;
        right_sum <= right_sum + elem_ext;
        if (keep) begin
          marks[scan_idx] <= 1'b1;
          kept            <= kept + CNT_BITS'(1);
        end
      end
      if (cmd.emit_start) begin
        ptr     <= '0;
        emitted <= '0;
      end
      if (cmd.emit_step) begin
        ptr <= ptr + CNT_BITS'(1);
      end
      if (cmd.out_load) begin
        emitted <= emitted + CNT_BITS'(1);
      end
      if (cmd.clear) begin
        fill <= '0;
        kept <= '0;
        ovf  <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load || cmd.out_none) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value     <= DATA_W'(rd_data);
      out_total     <= TOTAL_W'(kept);
      out_last      <= ((emitted + CNT_BITS'(1)) == kept);
      out_none_flag <= 1'b0;
      out_drop      <= ovf;
    end else if (cmd.out_none) begin
      out_value     <= '0;
      out_total     <= '0;
      out_last      <= 1'b1;
      out_none_flag <= 1'b1;
      out_drop      <= ovf;
    end
  end

  assign m_tdata = {(OUT_DATA_W - DATA_W - TOTAL_W)'(0), out_total, out_value};
  assign m_tlast = out_last;
  assign m_tuser = {out_drop, out_none_flag};

  assign status.scan_last = (ptr == CNT_BITS'(1));
  assign status.emit_last = ((ptr + CNT_BITS'(1)) == fill);
  assign status.mark_set  = marks[emit_idx];
  assign status.kept_zero = (kept == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_BITS'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept <= fill)
    else $error("kept count exceeds list length");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_none) |-> status.out_free)
    else $error("output register overwritten");

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_none) |=> m_tvalid)
    else $error("loaded result not presented");

endmodule
